// ===== hw/rtl/rope_pkg.sv =====
// ----------------------------------------------------------------------------
// rope_pkg: shared types and constants for the rotary position embedding block
// Fixed field widths of the streaming words and the tag carried by each pair.
// ----------------------------------------------------------------------------
package rope_pkg;

  // Field widths of the stream words
  localparam int DATA_W    = 16;  // element, cosine and sine words
  localparam int INDEX_W   = 8;   // result index
  localparam int ROW_LEN_W = 9;   // row length register

  // Arithmetic widths: 16x16 products and their rounded sum
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;

  // Row length after reset
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = ROW_LEN_W'(128);

  // Indexes and end-of-row flag travelling with one rotated pair
  typedef struct packed {
    logic [INDEX_W-1:0] idx_lo;   // index j of the first result
    logic [INDEX_W-1:0] idx_hi;   // index half+j of the second result
    logic               last;     // second result closes the row
  } pair_tag_t;

endpackage

// ===== hw/rtl/rope_in_if.sv =====
// ----------------------------------------------------------------------------
// rope_in_if: input element channel
// Valid/ready channel carrying one element with its cosine and sine.
// ----------------------------------------------------------------------------
interface rope_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rope_pkg::DATA_W-1:0] element_value;
  logic signed [rope_pkg::DATA_W-1:0] cos_value;
  logic signed [rope_pkg::DATA_W-1:0] sin_value;

  modport source (output valid, output element_value, output cos_value,
                  output sin_value, input ready);
  modport sink   (input valid, input element_value, input cos_value,
                  input sin_value, output ready);
endinterface

// ===== hw/rtl/rope_out_if.sv =====
// ----------------------------------------------------------------------------
// rope_out_if: rotated element channel
// Valid/ready channel carrying one rotated element, its index and row end.
// ----------------------------------------------------------------------------
interface rope_out_if;
  logic                                valid;
  logic                                ready;
  logic        [rope_pkg::INDEX_W-1:0] out_index;
  logic signed [rope_pkg::DATA_W-1:0]  out_value;
  logic                                row_done;

  modport source (output valid, output out_index, output out_value,
                  output row_done, input ready);
  modport sink   (input valid, input out_index, input out_value,
                  input row_done, output ready);
endinterface

// ===== hw/rtl/rotary_position_embedding.sv =====
// ----------------------------------------------------------------------------
// rotary_position_embedding: rotate-half RoPE over a streamed head row
// First-half elements are stored with their angles; each second-half element
// is paired with its stored partner and yields two rotated, rounded words.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake          payload
//  item_i      in   valid/ready        element_value, cos_value, sin_value
//  result_o    out  valid/ready        out_index, out_value, row_done
//  row_length  in   row_length_we_i    row_length_i (9 bits)
//
//  A first-half word writes the pair memory only. A second-half word reads
//  its partner into stage 1 at the accept edge, is multiplied in stage 2 and
//  is rounded and saturated into the pair output register, which drives the
//  first result word. The single result port sends two words per pair, so a
//  new pair replaces a held one only as the second word of the held pair
//  is taken. Reset sets the row length to 128 and the row position to 0; the
//  pair memory is not cleared. A stalled result port backs up through the
//  three stages; first-half words are still taken while the pipeline is full.
//
module rotary_position_embedding #(
  parameter int MAX_ROW_LENGTH      = 256,
  parameter int VALUE_BITS          = 16,
  parameter int ANGLE_FRACTION_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             row_length_we_i,
  input  logic [rope_pkg::ROW_LEN_W-1:0]   row_length_i,
  rope_in_if.sink                          item_i,
  rope_out_if.source                       result_o
);

  localparam int HALF_DEPTH = MAX_ROW_LENGTH / 2;
  localparam int J_W        = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int POS_W      = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W      = ($clog2(MAX_ROW_LENGTH + 1) > rope_pkg::ROW_LEN_W) ?
                              $clog2(MAX_ROW_LENGTH + 1) : rope_pkg::ROW_LEN_W;
  localparam int DW         = rope_pkg::DATA_W;
  localparam int RAM_W      = 3 * DW;
  localparam int SUM_W      = rope_pkg::SUM_W;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_LENGTH - (MAX_ROW_LENGTH % 2));

  localparam logic signed [SUM_W-1:0] RND_BIAS =
    SUM_W'(64'sd1 <<< (ANGLE_FRACTION_BITS - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Round to nearest (ties up), drop the angle fraction, saturate, keep 16 bits
  function automatic logic signed [DW-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] clipped;
    shifted = (sum + RND_BIAS) >>> ANGLE_FRACTION_BITS;
    if (shifted > SAT_HI) begin
      clipped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clipped = SAT_LO;
    end else begin
      clipped = shifted;
    end
    return clipped[DW-1:0];
  endfunction

  // Configuration and row position
  logic [rope_pkg::ROW_LEN_W-1:0] row_length_q;
  logic [POS_W-1:0]               row_pos_q, row_pos_d;

  // Stage 1: partner read from memory plus incoming element
  logic                           s1_valid_q;
  logic signed [DW-1:0]           s1_b_q;
  rope_pkg::pair_tag_t            s1_tag_q;
  logic [RAM_W-1:0]               ram_rdata;

  // Stage 2: products
  logic                           s2_valid_q;
  logic signed [rope_pkg::PROD_W-1:0] p_ac_q, p_bs_q, p_bc_q, p_as_q;
  rope_pkg::pair_tag_t            s2_tag_q;

  // Pair output register
  logic                           pair_valid_q;
  logic                           phase_q;
  logic signed [DW-1:0]           v_lo_q, v_hi_q;
  rope_pkg::pair_tag_t            pair_tag_q;

  // Handshake and row decode
  logic             in_acc;
  logic             pair_ready, s2_ready, s1_ready;
  logic [LEN_W-1:0] len_raw, eff_len, half, pos_ext, pos_eff, pos_inc, pair_off;
  logic             second, last;
  logic [J_W-1:0]   wr_addr, rd_addr;
  logic signed [DW-1:0] ram_a, ram_c, ram_s;

  // Effective row length: even, clamped to [2, MAX_ROW_LENGTH]
  always_comb begin
    len_raw = LEN_W'({row_length_q[rope_pkg::ROW_LEN_W-1:1], 1'b0});
    if (len_raw < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (len_raw > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_raw;
    end
    half = eff_len >> 1;
  end

  // Position decode for the word at the input
  always_comb begin
    pos_ext  = LEN_W'(row_pos_q);
    pos_eff  = (pos_ext >= eff_len) ? '0 : pos_ext;
    pos_inc  = pos_eff + LEN_W'(1);
    second   = (pos_eff >= half);
    last     = (pos_inc >= eff_len);
    pair_off = pos_eff - half;
    wr_addr  = pos_eff[J_W-1:0];
    rd_addr  = pair_off[J_W-1:0];
    if (!second) begin
      row_pos_d = pos_inc[POS_W-1:0];
    end else if (last) begin
      row_pos_d = '0;
    end else begin
      row_pos_d = pos_inc[POS_W-1:0];
    end
  end

  // Stage readiness, back to front
  assign pair_ready  = !pair_valid_q || (result_o.ready && phase_q);
  assign s2_ready    = !s2_valid_q || pair_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign item_i.ready = !second || s1_ready;
  assign in_acc      = item_i.valid && item_i.ready;

  // First-half store: element, cosine, sine in one word
  rope_ram #(
    .WIDTH (RAM_W),
    .DEPTH (HALF_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && !second),
    .waddr_i (wr_addr),
    .wdata_i ({item_i.element_value, item_i.cos_value, item_i.sin_value}),
    .re_i    (in_acc && second),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign ram_a = $signed(ram_rdata[3*DW-1:2*DW]);
  assign ram_c = $signed(ram_rdata[2*DW-1:DW]);
  assign ram_s = $signed(ram_rdata[DW-1:0]);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= rope_pkg::ROW_LEN_RESET;
      row_pos_q    <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      pair_valid_q <= 1'b0;
      phase_q      <= 1'b0;
    end else begin
      if (row_length_we_i) begin
        row_length_q <= row_length_i;
        row_pos_q    <= '0;
      end else if (in_acc) begin
        row_pos_q <= row_pos_d;
      end
      if (s1_ready) begin
        s1_valid_q <= in_acc && second;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (pair_ready) begin
        pair_valid_q <= s2_valid_q;
      end
      if (pair_valid_q && result_o.ready) begin
        phase_q <= !phase_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && second) begin
      s1_b_q          <= item_i.element_value;
      s1_tag_q.idx_lo <= rope_pkg::INDEX_W'(rd_addr);
      s1_tag_q.idx_hi <= rope_pkg::INDEX_W'(pos_eff);
      s1_tag_q.last   <= last;
    end
    if (s2_ready && s1_valid_q) begin
      p_ac_q   <= rope_pkg::PROD_W'(ram_a) * rope_pkg::PROD_W'(ram_c);
      p_bs_q   <= rope_pkg::PROD_W'(s1_b_q) * rope_pkg::PROD_W'(ram_s);
      p_bc_q   <= rope_pkg::PROD_W'(s1_b_q) * rope_pkg::PROD_W'(ram_c);
      p_as_q   <= rope_pkg::PROD_W'(ram_a) * rope_pkg::PROD_W'(ram_s);
      s2_tag_q <= s1_tag_q;
    end
    if (pair_ready && s2_valid_q) begin
      v_lo_q     <= round_sat(SUM_W'(p_ac_q) - SUM_W'(p_bs_q));
      v_hi_q     <= round_sat(SUM_W'(p_bc_q) + SUM_W'(p_as_q));
      pair_tag_q <= s2_tag_q;
    end
  end

  // Result word: index j first, then index half+j
  assign result_o.valid     = pair_valid_q;
  assign result_o.out_index = phase_q ? pair_tag_q.idx_hi : pair_tag_q.idx_lo;
  assign result_o.out_value = phase_q ? v_hi_q : v_lo_q;
  assign result_o.row_done  = phase_q && pair_tag_q.last;

  // Checks
  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(row_pos_q) < eff_len)
    else $error("row position beyond effective row length");

  a_pair_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && phase_q) |=> !phase_q)
    else $error("pair phase did not return to first word");

  a_read_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && second) |=> s1_valid_q)
    else $error("second-half word lost before multiply stage");

  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(ram_rdata)))
    else $error("partner data changed while stage 1 stalled");

endmodule

// ===== hw/rtl/rope_ram.sv =====
// ----------------------------------------------------------------------------
// rope_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rope_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for rotary_position_embedding
// Streams head rows through the rotate-half block under several row lengths
// and idling patterns. A software copy of the row store predicts every rotated
// word, and each word taken from the result port is checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int DATA_W    = rope_pkg::DATA_W;
  localparam int INDEX_W   = rope_pkg::INDEX_W;
  localparam int ROW_LEN_W = rope_pkg::ROW_LEN_W;

  localparam int MAX_ROW_LENGTH      = 256;
  localparam int VALUE_BITS          = 16;
  localparam int ANGLE_FRACTION_BITS = 14;
  localparam int HALF_DEPTH          = MAX_ROW_LENGTH / 2;

  localparam int SETTLE_CYCLES = 8;      // pipeline depth plus margin
  localparam int DRAIN_CYCLES  = 20000;
  localparam int TAIL_CYCLES   = 10;
  localparam int TIMEOUT_UNITS = 8_000_000;

  localparam logic signed [DATA_W-1:0] VALUE_MAX  = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] VALUE_MIN  = 16'sh8000;
  localparam logic signed [DATA_W-1:0] ANGLE_ONE  = 16'sd16384;  // 1.0 in Q1.14
  localparam logic signed [DATA_W-1:0] ANGLE_HALF = 16'sd8192;   // 0.5 in Q1.14

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
    logic               done;
  } rotated_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 row_length_we_i;
  logic [ROW_LEN_W-1:0] row_length_i;

  rope_in_if  item_if ();
  rope_out_if result_if ();

  rotary_position_embedding #(
    .MAX_ROW_LENGTH     (MAX_ROW_LENGTH),
    .VALUE_BITS         (VALUE_BITS),
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_length_we_i(row_length_we_i),
    .row_length_i   (row_length_i),
    .item_i         (item_if),
    .result_o       (result_if)
  );

  always #10 clk_i = ~clk_i;

  // Idling knobs, in percent
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int mismatch_count = 0;

  // Predicted row state and the rotated words still to arrive
  logic [ROW_LEN_W-1:0]      row_len_reg;
  int                        row_pos;
  logic signed [DATA_W-1:0]  held_x   [HALF_DEPTH];
  logic signed [DATA_W-1:0]  held_cos [HALF_DEPTH];
  logic signed [DATA_W-1:0]  held_sin [HALF_DEPTH];
  rotated_word_t             awaited_words [$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Row length in use: low bit dropped, clamped to [2, MAX_ROW_LENGTH]
  function automatic int row_span();
    int len;
    len = int'(row_len_reg) & 'h1fe;
    if (len < 2) len = 2;
    if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
    return len;
  endfunction

  // Q.14 sum to Q16.0 value: round half up, then saturate
  function automatic logic [DATA_W-1:0] round_to_value(input longint sum);
    longint r;
    longint hi;
    hi = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    r  = (sum + (longint'(1) <<< (ANGLE_FRACTION_BITS - 1))) >>> ANGLE_FRACTION_BITS;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[DATA_W-1:0];
  endfunction

  // Advance the predicted row by one accepted element word
  task automatic rotate_element(input logic signed [DATA_W-1:0] x, c, s);
    int            len;
    int            half;
    int            pos;
    int            j;
    longint        a;
    longint        b;
    longint        cj;
    longint        sj;
    rotated_word_t w;
    len  = row_span();
    half = len / 2;
    pos  = (row_pos >= len) ? 0 : row_pos;
    if (pos < half) begin
      held_x[pos % HALF_DEPTH]   = x;
      held_cos[pos % HALF_DEPTH] = c;
      held_sin[pos % HALF_DEPTH] = s;
      row_pos = pos + 1;
    end else begin
      // second half: angles on this word are ignored
      j  = (pos - half) % HALF_DEPTH;
      a  = held_x[j];
      b  = x;
      cj = held_cos[j];
      sj = held_sin[j];
      w.index = INDEX_W'(j);
      w.value = round_to_value(a * cj - b * sj);
      w.done  = 1'b0;
      awaited_words.push_back(w);
      w.index = INDEX_W'(pos);
      w.value = round_to_value(b * cj + a * sj);
      w.done  = (pos + 1 >= len);
      awaited_words.push_back(w);
      row_pos = (pos + 1 >= len) ? 0 : pos + 1;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return DATA_W'(int'($urandom_range(16)) - 8);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_angle();
    case ($urandom_range(9))
      0: return ANGLE_ONE;
      1: return -ANGLE_ONE;
      2: return '0;
      default: return DATA_W'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Send one element word after random idle time; valid stays high afterwards so back-to-back words have no gap
  task automatic send_element(input logic signed [DATA_W-1:0] x, c, s);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.element_value <= x;
    item_if.cos_value     <= c;
    item_if.sin_value     <= s;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    rotate_element(x, c, s);
  endtask

  task automatic send_row(input int n);
    for (int i = 0; i < n; i++) send_element(pick_value(), pick_angle(), pick_angle());
  endtask

  // Register write, only once the block has drained
  task automatic write_row_length(input logic [ROW_LEN_W-1:0] v);
    @(negedge clk_i) item_if.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    row_length_we_i <= 1'b1;
    row_length_i    <= v;
    @(posedge clk_i);
    row_len_reg = v;
    row_pos     = 0;
    @(negedge clk_i) row_length_we_i <= 1'b0;
  endtask

  // One full row at the length left by reset
  task automatic test_default_length();
    src_idle_pct  = 22;
    snk_stall_pct = 22;
    send_row(128);
  endtask

  // Extremes, rounding ties, clamped lengths and an abandoned row
  task automatic test_corners();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_row_length(ROW_LEN_W'(2));
    // unit angle passes values through; second-half angles are junk
    send_element(VALUE_MAX, ANGLE_ONE, 16'sd0);
    send_element(VALUE_MIN, 16'sd1234, -16'sd77);
    // positive saturation
    send_element(VALUE_MIN, -ANGLE_ONE, -ANGLE_ONE);
    send_element(VALUE_MAX, 16'sd0, 16'sd0);
    // negative saturation
    send_element(VALUE_MIN, ANGLE_ONE, ANGLE_ONE);
    send_element(VALUE_MAX, -16'sd5, 16'sd9);
    // exact halves round toward plus infinity
    send_element(16'sd1, ANGLE_HALF, 16'sd0);
    send_element(16'sd0, ANGLE_ONE, ANGLE_ONE);
    send_element(-16'sd1, ANGLE_HALF, -ANGLE_HALF);
    send_element(16'sd0, -ANGLE_ONE, 16'sd0);
    // lengths below two and length three fall back to a pair
    write_row_length(ROW_LEN_W'(0));
    send_element(16'sh1000, -ANGLE_ONE, ANGLE_HALF);
    send_element(16'sh2000, 16'sd0, 16'sd0);
    write_row_length(ROW_LEN_W'(1));
    send_element(-16'sh1000, ANGLE_HALF, ANGLE_HALF);
    send_element(16'sh3000, ANGLE_ONE, -ANGLE_ONE);
    write_row_length(ROW_LEN_W'(3));
    send_element(16'sh0123, 16'sd4096, -16'sd4096);
    send_element(-16'sh0456, 16'sd0, 16'sd0);
    // a write part way through a row restarts at position zero
    write_row_length(ROW_LEN_W'(6));
    send_element(VALUE_MAX, ANGLE_ONE, ANGLE_ONE);
    send_element(VALUE_MIN, ANGLE_ONE, ANGLE_ONE);
    write_row_length(ROW_LEN_W'(4));
    send_row(4);
  endtask

  // Oversized length clamps to the largest row
  task automatic test_max_length();
    src_idle_pct  = 0;
    snk_stall_pct = 64;
    write_row_length(ROW_LEN_W'(511));
    send_row(MAX_ROW_LENGTH);
  endtask

  // Mostly short rows with random content, a rare long one, some left unfinished
  task automatic test_random_rows(input int src_pct, snk_pct, budget);
    int                   sent;
    int                   len;
    int                   rows;
    logic [ROW_LEN_W-1:0] setting;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(15))
        0:       setting = ROW_LEN_W'($urandom_range(511, 256));
        1, 2:    setting = ROW_LEN_W'($urandom_range(127, 41));
        default: setting = ROW_LEN_W'($urandom_range(40, 0));
      endcase
      write_row_length(setting);
      len  = row_span();
      rows = (len <= 40) ? $urandom_range(4, 1) : 1;
      for (int r = 0; r < rows; r++) send_row(len);
      sent += rows * len;
      // partial row, dropped by the next write
      if ($urandom_range(4) == 0) begin
        len = $urandom_range(len - 1, 1);
        send_row(len);
        sent += len;
      end
    end
  endtask

  // Result port back-pressure
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_words
    rotated_word_t due;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, index %0d value %0d",
                                  result_if.out_index, result_if.out_value));
      end else begin
        due = awaited_words.pop_front();
        if (result_if.out_index !== due.index)
          report_mismatch($sformatf("out_index %0d, want %0d",
                                    result_if.out_index, due.index));
        if (result_if.out_value !== due.value)
          report_mismatch($sformatf("out_value %0d at index %0d, want %0d",
                                    result_if.out_value, due.index, $signed(due.value)));
        if (result_if.row_done !== due.done)
          report_mismatch($sformatf("row_done %0b at index %0d, want %0b",
                                    result_if.row_done, due.index, due.done));
      end
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("rotary_position_embedding: mismatch");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    row_length_we_i       = 1'b0;
    row_length_i          = '0;
    item_if.valid         = 1'b0;
    item_if.element_value = '0;
    item_if.cos_value     = '0;
    item_if.sin_value     = '0;
    row_len_reg           = rope_pkg::ROW_LEN_RESET;
    row_pos               = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_default_length();
    test_corners();
    test_max_length();
    test_random_rows(0, 0, 340);
    test_random_rows(64, 0, 340);
    test_random_rows(0, 64, 340);
    test_random_rows(22, 22, 340);

    // drain, then watch for stray words
    @(negedge clk_i) item_if.valid <= 1'b0;
    for (int n = 0; n < DRAIN_CYCLES && awaited_words.size() != 0; n++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", awaited_words.size()));

    if (mismatch_count == 0) begin
      $display("rotary_position_embedding: match");
    end else begin
      $display("rotary_position_embedding: mismatch");
    end
    $finish;
  end

endmodule
